>>> sv/rwh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the radial-weight heightmap interpolator.
package rwh_pkg;

  localparam int COORD_W = 32;
  localparam int CELL_W  = 12;
  localparam int SCALE_W = 24;
  localparam int HGT_W   = 24;

  // Radius of influence: 50 quads, in Q.16
  localparam logic [22:0] RADIUS_Q16 = 23'd3276800;
  // 50 * 2^16 = 25 * 2^17; index divide works on units of 2^17
  localparam int          RAD_SHIFT  = 17;
  localparam logic [4:0]  RAD_UNITS  = 5'd25;
  // floor(2^16 / 25), an underestimate of 1/25
  localparam logic [11:0] RECIP25    = 12'd2621;
  // 0.1 in Q0.16
  localparam logic [15:0] BIAS_Q16   = 16'd6554;

  // Square root: 46-bit radicand, 23 result bits, one bit per stage
  localparam int SQ_W = 46;
  localparam int NSQ  = 23;

  localparam int HGT_MAX = 8388607;
  localparam int HGT_MIN = -8388608;

  localparam logic [1:0] REQ_CLEAR   = 2'd0;
  localparam logic [1:0] REQ_LOAD    = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  localparam logic [1:0] CFG_QPU  = 2'd0;
  localparam logic [1:0] CFG_IMH  = 2'd1;
  localparam logic [1:0] CFG_ORGX = 2'd2;
  localparam logic [1:0] CFG_ORGZ = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
  } pt_t;

  // Sideband that travels with one point down the weight pipeline
  typedef struct packed {
    logic                      vld;
    logic                      last;
    logic                      far;
    logic signed [COORD_W-1:0] y;
  } pl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_SCALE,
    ST_DONE
  } rwh_state_t;

endpackage

>>> sv/rwh_point_cell.sv
`timescale 1ns / 1ps
// One control-point cell of the circular point chain.
module rwh_point_cell (
  input  logic         clk,
  input  logic         load_en,
  input  logic         shift_en,
  input  rwh_pkg::pt_t load_pt,
  input  rwh_pkg::pt_t shift_in,
  output rwh_pkg::pt_t pt_q
);
  import rwh_pkg::*;

  pt_t pt_r;

  // Load wins; otherwise take the neighbor's point while the chain rotates
  always_ff @(posedge clk) begin
    if (load_en) begin
      pt_r <= load_pt;
    end else if (shift_en) begin
      pt_r <= shift_in;
    end
  end

  assign pt_q = pt_r;

endmodule

>>> sv/rwh_sqrt_cell.sv
`timescale 1ns / 1ps
// One stage of the pipelined integer square root, one result bit per stage.
module rwh_sqrt_cell #(
  parameter int SHIFT = 44
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [rwh_pkg::SQ_W-1:0] v_i,
  input  logic [rwh_pkg::SQ_W-1:0] r_i,
  input  rwh_pkg::pl_t             pl_i,
  output logic [rwh_pkg::SQ_W-1:0] v_o,
  output logic [rwh_pkg::SQ_W-1:0] r_o,
  output rwh_pkg::pl_t             pl_o
);
  import rwh_pkg::*;

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << SHIFT;

  logic [SQ_W-1:0] trial;
  logic [SQ_W-1:0] v_nxt;
  logic [SQ_W-1:0] r_nxt;
  logic [SQ_W-1:0] v_r;
  logic [SQ_W-1:0] r_r;
  pl_t             pl_r;

  always_comb begin
    trial = r_i + BIT;
    if (v_i >= trial) begin
      v_nxt = v_i - trial;
      r_nxt = (r_i >> 1) + BIT;
    end else begin
      v_nxt = v_i;
      r_nxt = r_i >> 1;
    end
  end

  // Drop the valid and last flags on reset; the data needs no clearing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_r.vld  <= 1'b0;
      pl_r.last <= 1'b0;
    end else begin
      pl_r.vld  <= pl_i.vld;
      pl_r.last <= pl_i.last;
    end
    pl_r.far <= pl_i.far;
    pl_r.y   <= pl_i.y;
    v_r      <= v_nxt;
    r_r      <= r_nxt;
  end

  assign v_o  = v_r;
  assign r_o  = r_r;
  assign pl_o = pl_r;

endmodule

>>> sv/radial_weight_heightmap_interp_unit.sv
`timescale 1ns / 1ps
// Top level: radial-weight heightmap interpolator with a rotating point chain.
// Clear, a stored load and an unknown request give no output word; a load into a full store
// is answered with a full-store word, registered through the done state. A compute word passes
// through the chain sweep, the 31-stage weight pipeline, the bit-serial divide and the scale.
// Reset (rst_n low, synchronous) empties the store, drops any output word, loads defaults.
module radial_weight_heightmap_interp_unit #(
  parameter int MAX_POINTS        = 16,
  parameter int WEIGHT_TABLE_BITS = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  // Request channel
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] point_x, [63:32] point_z, [95:64] point_y, [107:96] cell_col,
  // [119:108] cell_row
  input  logic [119:0] in_tdata,
  // [1:0] req_type
  input  logic [1:0]   in_tuser,
  // Result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  // [23:0] height_out, [35:24] out_col, [47:36] out_row
  output logic [47:0]  out_tdata,
  // [0] saturated, [1] store_full
  output logic [1:0]   out_tuser,
  // Register write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import rwh_pkg::*;

  localparam int TBL  = 1 << WEIGHT_TABLE_BITS;
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int KW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NUMW = 49 + $clog2(MAX_POINTS + 1);
  localparam int DENW = 17 + $clog2(MAX_POINTS + 1);
  localparam int QW   = NUMW + 1;
  localparam int HW   = QW - 23;
  localparam int PHW  = HW + 25;
  localparam int TW   = QW + 26;
  localparam int DCW  = $clog2(NUMW + 1);
  localparam int DSW  = 23 - (RAD_SHIFT - WEIGHT_TABLE_BITS);

  // Weight curve ((1 - d/50)^1.3) in Q0.16, built at elaboration.
  function automatic logic [TBL*16-1:0] build_tbl();
    logic [TBL*16-1:0] tbl;
    logic [63:0] u, x3, lo, hi, mid, p, y;
    tbl = '0;
    for (int i = 0; i < TBL; i++) begin
      u  = 64'(TBL - i) << (16 - WEIGHT_TABLE_BITS);
      x3 = (u * u * u) >> 16;
      lo = 64'd0;
      hi = 64'd65536;
      for (int s = 0; s < 18; s++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          p   = mid << 16;
          for (int k = 0; k < 9; k++) begin
            p = (p * mid) >> 16;
          end
          if (p <= x3) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      y = (u * lo) >> 16;
      tbl[i*16 +: 16] = (y > 64'd65535) ? 16'hFFFF : y[15:0];
    end
    return tbl;
  endfunction

  localparam logic [TBL*16-1:0] WTBL = build_tbl();

  // ---------------------------------------------------------------- fields
  logic [1:0]               req;
  pt_t                      in_pt;
  logic [CELL_W-1:0]        in_col;
  logic [CELL_W-1:0]        in_row;
  logic                     in_acc;

  assign req    = in_tuser;
  assign in_pt.x = in_tdata[31:0];
  assign in_pt.z = in_tdata[63:32];
  assign in_pt.y = in_tdata[95:64];
  assign in_col = in_tdata[107:96];
  assign in_row = in_tdata[119:108];
  assign in_acc = in_tvalid && in_tready;

  // ---------------------------------------------------------------- registers
  logic [SCALE_W-1:0]        qpu_r;
  logic [SCALE_W-1:0]        imh_r;
  logic signed [COORD_W-1:0] orgx_r;
  logic signed [COORD_W-1:0] orgz_r;

  // Configuration must be written only while idle; the block does not enforce this, cfg_ready is tied high
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qpu_r  <= SCALE_W'(65536);
      imh_r  <= SCALE_W'(65536);
      orgx_r <= '0;
      orgz_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_QPU:  qpu_r  <= cfg_data[SCALE_W-1:0];
        CFG_IMH:  imh_r  <= cfg_data[SCALE_W-1:0];
        CFG_ORGX: orgx_r <= cfg_data;
        CFG_ORGZ: orgz_r <= cfg_data;
        default:  qpu_r  <= qpu_r;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  rwh_state_t state_r, state_nxt;
  logic [CW-1:0]   count_r;
  logic [KW-1:0]   k_r;
  logic [DCW-1:0]  dcnt_r;
  logic            shift_en;
  logic            tail_last;
  logic            out_free;

  logic             out_valid_r;
  logic [HGT_W-1:0] out_hgt_r;
  logic [CELL_W-1:0] out_col_r;
  logic [CELL_W-1:0] out_row_r;
  logic             out_sat_r;
  logic             out_full_r;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    shift_en  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (req == REQ_COMPUTE) begin
            state_nxt = ST_SWEEP;
          end else if (req == REQ_LOAD && count_r == CW'(MAX_POINTS)) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SWEEP: begin
        shift_en = 1'b1;
        if (k_r == KW'(MAX_POINTS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tail_last) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (dcnt_r == DCW'(NUMW - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Point count: clear empties, a load into a free slot grows it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_acc && req == REQ_CLEAR) begin
      count_r <= '0;
    end else if (in_acc && req == REQ_LOAD && count_r != CW'(MAX_POINTS)) begin
      count_r <= count_r + CW'(1);
    end
  end

  // Sweep position: slot k sits at the head of the chain in sweep cycle k
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (state_r == ST_SWEEP) begin
      k_r <= (k_r == KW'(MAX_POINTS - 1)) ? '0 : k_r + KW'(1);
    end else begin
      k_r <= '0;
    end
  end

  // ---------------------------------------------------------------- point chain
  pt_t cell_q [MAX_POINTS];

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    localparam int NXT = (i + 1) % MAX_POINTS;
    logic ld;
    assign ld = in_acc && req == REQ_LOAD && count_r == CW'(i);
    rwh_point_cell u_cell (
      .clk      (clk),
      .load_en  (ld),
      .shift_en (shift_en),
      .load_pt  (in_pt),
      .shift_in (cell_q[NXT]),
      .pt_q     (cell_q[i])
    );
  end

  // ---------------------------------------------------------------- weight pipeline
  logic [CELL_W-1:0] col_r;
  logic [CELL_W-1:0] row_r;

  always_ff @(posedge clk) begin
    if (in_acc && req == REQ_COMPUTE) begin
      col_r <= in_col;
      row_r <= in_row;
    end
  end

  // Stage 1: offset from the terrain origin
  pl_t                s1_pl_r;
  logic signed [32:0] s1_dx_r, s1_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pl_r.vld  <= 1'b0;
      s1_pl_r.last <= 1'b0;
    end else begin
      s1_pl_r.vld  <= shift_en && (CW'(k_r) < count_r);
      s1_pl_r.last <= shift_en && (k_r == KW'(MAX_POINTS - 1));
    end
    s1_pl_r.far <= 1'b0;
    s1_pl_r.y   <= cell_q[0].y;
    s1_dx_r     <= 33'(cell_q[0].x) - 33'(orgx_r);
    s1_dz_r     <= 33'(cell_q[0].z) - 33'(orgz_r);
  end

  // Stage 2: scale to quad units, floor of the Q.16 product
  pl_t                s2_pl_r;
  logic signed [41:0] s2_px_r, s2_pz_r;
  logic signed [57:0] prod_x, prod_z;

  assign prod_x = 58'(s1_dx_r) * 58'($signed({1'b0, qpu_r}));
  assign prod_z = 58'(s1_dz_r) * 58'($signed({1'b0, qpu_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_pl_r.vld  <= 1'b0;
      s2_pl_r.last <= 1'b0;
    end else begin
      s2_pl_r.vld  <= s1_pl_r.vld;
      s2_pl_r.last <= s1_pl_r.last;
    end
    s2_pl_r.far <= s1_pl_r.far;
    s2_pl_r.y   <= s1_pl_r.y;
    s2_px_r     <= prod_x[57:16];
    s2_pz_r     <= prod_z[57:16];
  end

  // Stage 3: offset to the cell, magnitudes, box reject
  pl_t                s3_pl_r;
  logic [21:0]        s3_ax_r, s3_az_r;
  logic signed [42:0] dx, dz;
  logic [42:0]        ax, az;
  logic               box_far;

  always_comb begin
    dx = 43'(s2_px_r) - $signed({15'd0, col_r, 16'd0});
    dz = 43'(s2_pz_r) - $signed({15'd0, row_r, 16'd0});
    ax = dx[42] ? 43'(-dx) : 43'(dx);
    az = dz[42] ? 43'(-dz) : 43'(dz);
    box_far = (ax >= 43'(RADIUS_Q16)) || (az >= 43'(RADIUS_Q16));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_pl_r.vld  <= 1'b0;
      s3_pl_r.last <= 1'b0;
    end else begin
      s3_pl_r.vld  <= s2_pl_r.vld;
      s3_pl_r.last <= s2_pl_r.last;
    end
    s3_pl_r.far <= box_far;
    s3_pl_r.y   <= s2_pl_r.y;
    s3_ax_r     <= ax[21:0];
    s3_az_r     <= az[21:0];
  end

  // Stage 4: squared distance
  pl_t             s4_pl_r;
  logic [SQ_W-1:0] s4_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_pl_r.vld  <= 1'b0;
      s4_pl_r.last <= 1'b0;
    end else begin
      s4_pl_r.vld  <= s3_pl_r.vld;
      s4_pl_r.last <= s3_pl_r.last;
    end
    s4_pl_r.far <= s3_pl_r.far;
    s4_pl_r.y   <= s3_pl_r.y;
    s4_sq_r     <= SQ_W'({22'd0, s3_ax_r} * {22'd0, s3_ax_r})
                 + SQ_W'({22'd0, s3_az_r} * {22'd0, s3_az_r});
  end

  // Square root chain: one result bit per cell
  logic [SQ_W-1:0] sq_v  [NSQ+1];
  logic [SQ_W-1:0] sq_r  [NSQ+1];
  pl_t             sq_pl [NSQ+1];

  assign sq_v[0]  = s4_sq_r;
  assign sq_r[0]  = '0;
  assign sq_pl[0] = s4_pl_r;

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    rwh_sqrt_cell #(.SHIFT(2 * (NSQ - 1 - j))) u_sq (
      .clk   (clk),
      .rst_n (rst_n),
      .v_i   (sq_v[j]),
      .r_i   (sq_r[j]),
      .pl_i  (sq_pl[j]),
      .v_o   (sq_v[j+1]),
      .r_o   (sq_r[j+1]),
      .pl_o  (sq_pl[j+1])
    );
  end

  // Stage 5: distance reject, estimate of the table index
  logic [22:0]     root_d;
  pl_t             s5_pl_r;
  logic [DSW-1:0]  s5_ds_r;
  logic [DSW-1:0]  s5_q0_r;
  logic [DSW+11:0] q0_prod;

  assign root_d  = sq_r[NSQ][22:0];
  assign q0_prod = (DSW+12)'(root_d >> (RAD_SHIFT - WEIGHT_TABLE_BITS)) * (DSW+12)'(RECIP25);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_pl_r.vld  <= 1'b0;
      s5_pl_r.last <= 1'b0;
    end else begin
      s5_pl_r.vld  <= sq_pl[NSQ].vld;
      s5_pl_r.last <= sq_pl[NSQ].last;
    end
    s5_pl_r.far <= sq_pl[NSQ].far || (root_d >= RADIUS_Q16);
    s5_pl_r.y   <= sq_pl[NSQ].y;
    s5_ds_r     <= DSW'(root_d >> (RAD_SHIFT - WEIGHT_TABLE_BITS));
    s5_q0_r     <= DSW'(q0_prod[DSW+11:16]);
  end

  // Stage 6: correct the estimate by one
  pl_t                          s6_pl_r;
  logic [WEIGHT_TABLE_BITS-1:0] s6_idx_r;
  logic [DSW-1:0]               rem25;
  logic [DSW-1:0]               idx_full;

  always_comb begin
    rem25    = s5_ds_r - DSW'(s5_q0_r * DSW'(RAD_UNITS));
    idx_full = (rem25 >= DSW'(RAD_UNITS)) ? s5_q0_r + DSW'(1) : s5_q0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_pl_r.vld  <= 1'b0;
      s6_pl_r.last <= 1'b0;
    end else begin
      s6_pl_r.vld  <= s5_pl_r.vld;
      s6_pl_r.last <= s5_pl_r.last;
    end
    s6_pl_r.far <= s5_pl_r.far;
    s6_pl_r.y   <= s5_pl_r.y;
    s6_idx_r    <= idx_full[WEIGHT_TABLE_BITS-1:0];
  end

  // Stage 7: weight ROM read, zero outside the radius
  pl_t         s7_pl_r;
  logic [15:0] s7_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_pl_r.vld  <= 1'b0;
      s7_pl_r.last <= 1'b0;
    end else begin
      s7_pl_r.vld  <= s6_pl_r.vld;
      s7_pl_r.last <= s6_pl_r.last;
    end
    s7_pl_r.far <= s6_pl_r.far;
    s7_pl_r.y   <= s6_pl_r.y;
    s7_w_r      <= s6_pl_r.far ? 16'd0 : WTBL[s6_idx_r*16 +: 16];
  end

  // Stage 8: weighted height
  logic               s8_vld_r;
  logic               s8_last_r;
  logic [15:0]        s8_w_r;
  logic signed [48:0] s8_wy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r  <= 1'b0;
      s8_last_r <= 1'b0;
    end else begin
      s8_vld_r  <= s7_pl_r.vld;
      s8_last_r <= s7_pl_r.last;
    end
    s8_w_r  <= s7_w_r;
    s8_wy_r <= 49'($signed({1'b0, s7_w_r})) * 49'(s7_pl_r.y);
  end

  assign tail_last = s8_last_r;

  // Accumulate numerator and denominator over the valid slots
  logic signed [NUMW-1:0] num_r;
  logic [DENW-1:0]        den_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_SWEEP && k_r == '0) begin
      num_r <= '0;
      den_r <= DENW'(BIAS_Q16);
    end else if (s8_vld_r) begin
      num_r <= num_r + NUMW'(s8_wy_r);
      den_r <= den_r + DENW'(s8_w_r);
    end
  end

  // ---------------------------------------------------------------- divider
  // Restoring divide on the magnitude, one quotient bit a cycle
  logic [NUMW-1:0] dq_r;
  logic [DENW-1:0] drem_r;
  logic            dneg_r;
  logic [DENW:0]   rem_sh;
  logic            qbit;

  always_comb begin
    rem_sh = {drem_r, dq_r[NUMW-1]};
    qbit   = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      dq_r   <= num_r[NUMW-1] ? NUMW'(-num_r) : NUMW'(num_r);
      dneg_r <= num_r[NUMW-1];
      drem_r <= '0;
      dcnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      drem_r <= qbit ? DENW'(rem_sh - {1'b0, den_r}) : rem_sh[DENW-1:0];
      dq_r   <= {dq_r[NUMW-2:0], qbit};
      dcnt_r <= dcnt_r + DCW'(1);
    end
  end

  // ---------------------------------------------------------------- scale
  logic signed [QW-1:0]  quot;
  logic [46:0]           plo_r;
  logic signed [PHW-1:0] phi_r;
  logic signed [TW-1:0]  total;
  logic signed [TW-17:0] hgt;
  logic [HGT_W-1:0]      hgt_sat;
  logic                  sat;

  assign quot = dneg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});

  // Split the quotient at bit 23 into a low and a high part, each multiplied by the height scale
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      plo_r <= {24'd0, quot[22:0]} * {23'd0, imh_r};
      phi_r <= PHW'($signed(quot[QW-1:23])) * PHW'($signed({1'b0, imh_r}));
    end
  end

  always_comb begin
    total = (TW'(phi_r) <<< 23) + $signed(TW'(plo_r));
    hgt   = total[TW-1:16];
    if (hgt > (TW-16)'(HGT_MAX)) begin
      hgt_sat = HGT_W'(HGT_MAX);
      sat     = 1'b1;
    end else if (hgt < (TW-16)'(HGT_MIN)) begin
      hgt_sat = HGT_W'(HGT_MIN);
      sat     = 1'b1;
    end else begin
      hgt_sat = hgt[HGT_W-1:0];
      sat     = 1'b0;
    end
  end

  // Result staging: a full-store word or a finished height
  logic [HGT_W-1:0]  res_hgt_r;
  logic [CELL_W-1:0] res_col_r;
  logic [CELL_W-1:0] res_row_r;
  logic              res_sat_r;
  logic              res_full_r;

  always_ff @(posedge clk) begin
    if (in_acc && req == REQ_LOAD) begin
      res_hgt_r  <= '0;
      res_col_r  <= '0;
      res_row_r  <= '0;
      res_sat_r  <= 1'b0;
      res_full_r <= 1'b1;
    end else if (state_r == ST_SCALE) begin
      res_hgt_r  <= hgt_sat;
      res_col_r  <= col_r;
      res_row_r  <= row_r;
      res_sat_r  <= sat;
      res_full_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_hgt_r  <= res_hgt_r;
      out_col_r  <= res_col_r;
      out_row_r  <= res_row_r;
      out_sat_r  <= res_sat_r;
      out_full_r <= res_full_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_row_r, out_col_r, out_hgt_r};
  assign out_tuser  = {out_full_r, out_sat_r};

endmodule

>>> sv/rwh_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the interpolator, bound to the top level.
module rwh_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [119:0] in_tdata,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata,
  input logic [1:0]   out_tuser,
  input logic         cfg_valid,
  input logic         cfg_ready,
  input logic [1:0]   cfg_index,
  input logic [31:0]  cfg_data
);
  import rwh_pkg::*;

  // Hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  // Drop any word on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A full-store word carries no height, cell or saturation
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 48'd0 && !out_tuser[0])
    else $error("full-store word carries data");

  // A compute request holds off the next request
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_COMPUTE |=> !in_tready)
    else $error("request accepted during compute");

endmodule

bind radial_weight_heightmap_interp_unit rwh_checker u_rwh_checker (.*);
